FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shorthand for clocked concurrent assertions with an active-low reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// when ante holds, cons holds at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/rc4sc_pkg.sv
// ---------------------------------------------------------------------------
// rc4sc_pkg
// types and constants shared by the rc4 stream cipher and its checker
// ---------------------------------------------------------------------------
package rc4sc_pkg;

	localparam int SBOX_DEPTH  = 256;
	localparam int BYTE_W      = 8;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;

	typedef logic [BYTE_W-1:0] byte_t;

	// opcode carried on s_tuser
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_DATA = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KS_RD_K,
		ST_KS_RD_J,
		ST_KS_WR_K,
		ST_KS_WR_J,
		ST_GEN_J,
		ST_GEN_T,
		ST_GEN_WR,
		ST_PUSH
	} state_t;

	// where the keystream byte comes from after the swap
	typedef enum logic [1:0] {
		KS_MEM,
		KS_FROM_I,
		KS_FROM_J
	} ks_src_t;

endpackage

FILE: sv/rc4_stream_cipher.sv
// ---------------------------------------------------------------------------
// rc4_stream_cipher
// rc4 key scheduling and keystream generation around one s-box memory
// ---------------------------------------------------------------------------
// Key bytes come in with s_tuser low and are taken one per cycle while idle;
// the one with s_tlast high starts key scheduling, 256 steps each through
// ST_KS_RD_K, ST_KS_RD_J, ST_KS_WR_K and ST_KS_WR_J, before the next word is
// taken. A data word (s_tuser high) passes through ST_GEN_J, ST_GEN_T and
// ST_GEN_WR when keyed and ST_PUSH when not, and is answered with one result
// word; keystream generation is bound by the s-box memory, which has one
// write port and a registered read port. A waiting result is held in the
// output register while the next word is taken; the block stalls only when a
// second result is ready before the first has left. Data sent before a key
// schedule is in force returns zeros with m_tuser set.
// ---------------------------------------------------------------------------
module rc4_stream_cipher
	import rc4sc_pkg::*;
#(
	parameter int KEY_MAX = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // data_byte[7:0]
	input  logic                   s_tuser,   // opcode
	input  logic                   s_tlast,   // last_key
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // out_byte[7:0], keystream_byte[15:8]
	output logic                   m_tuser    // not_keyed
);

	localparam int CNT_W  = $clog2(KEY_MAX + 1);
	localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(KEY_MAX);

	state_t state_q, state_d;

	// s-box memory with a valid bit per entry; an invalid entry reads as its index
	byte_t                 sbox_mem [SBOX_DEPTH];
	logic [SBOX_DEPTH-1:0] sbox_vld_q;
	byte_t                 sbox_rdata_q;
	logic                  sbox_rvld_q;
	byte_t                 sbox_raddr_q;
	byte_t                 sb_raddr, sb_waddr, sb_wdata, sb_rd;
	logic                  sb_we, sb_clr;

	byte_t                 key_mem [KEY_MAX];
	byte_t                 key_rd_q;

	logic [CNT_W-1:0]      count_q, len_q, kidx_inc;
	logic [KIDX_W-1:0]     kidx_q;
	logic                  keyed_q;
	byte_t                 i_q, j_q, si_q, sj_q, din_q;
	ks_src_t               ks_src_q;
	logic [OUT_TDATA_W-1:0] res_q, res_sel;
	logic                  res_nk_q, res_nk_sel;

	logic                  accept, out_free, out_load;
	byte_t                 j_ks, j_gen, t_idx, ks;

	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   m_tvalid_q, m_tuser_q;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign sb_rd    = sbox_rvld_q ? sbox_rdata_q : sbox_raddr_q;
	assign j_ks     = j_q + sb_rd + key_rd_q;
	assign j_gen    = j_q + sb_rd;
	assign t_idx    = si_q + sb_rd;
	assign kidx_inc = CNT_W'(kidx_q) + CNT_W'(1);

	always_comb begin
		case (ks_src_q)
			KS_FROM_I: ks = sj_q;
			KS_FROM_J: ks = si_q;
			default:   ks = sb_rd;
		endcase
	end

	always_comb begin
		if (state_q == ST_PUSH) begin
			res_sel    = res_q;
			res_nk_sel = res_nk_q;
		end else begin
			res_sel    = {ks, din_q ^ ks};
			res_nk_sel = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = (state_q == ST_IDLE);
		sb_raddr = i_q + 8'd1;
		sb_we    = 1'b0;
		sb_waddr = i_q;
		sb_wdata = sb_rd;
		sb_clr   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == OP_KEY) begin
						if (s_tlast) begin
							sb_clr  = 1'b1;
							state_d = ST_KS_RD_K;
						end
					end else if (keyed_q) begin
						state_d = ST_GEN_J;
					end else begin
						state_d = ST_PUSH;
					end
				end
			end
			ST_KS_RD_K: begin
				sb_raddr = i_q;
				state_d  = ST_KS_RD_J;
			end
			ST_KS_RD_J: begin
				sb_raddr = j_ks;
				state_d  = ST_KS_WR_K;
			end
			ST_KS_WR_K: begin
				sb_we    = 1'b1;
				sb_waddr = i_q;
				sb_wdata = sb_rd;
				state_d  = ST_KS_WR_J;
			end
			ST_KS_WR_J: begin
				sb_we    = 1'b1;
				sb_waddr = j_q;
				sb_wdata = si_q;
				state_d  = (i_q == 8'hFF) ? ST_IDLE : ST_KS_RD_K;
			end
			ST_GEN_J: begin
				sb_raddr = j_gen;
				state_d  = ST_GEN_T;
			end
			ST_GEN_T: begin
				// write s[i] and read s[t] together; s[i] and s[j] both read stale here, so forward
				sb_we    = 1'b1;
				sb_waddr = i_q;
				sb_wdata = sb_rd;
				sb_raddr = t_idx;
				state_d  = ST_GEN_WR;
			end
			ST_GEN_WR: begin
				sb_we    = 1'b1;
				sb_waddr = j_q;
				sb_wdata = si_q;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					state_d  = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// s-box storage
	always_ff @(posedge clk) begin
		if (sb_we) begin
			sbox_mem[sb_waddr] <= sb_wdata;
		end
		sbox_rdata_q <= sbox_mem[sb_raddr];
		sbox_raddr_q <= sb_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbox_vld_q  <= '0;
			sbox_rvld_q <= 1'b0;
		end else begin
			sbox_rvld_q <= sbox_vld_q[sb_raddr];
			if (sb_clr) begin
				sbox_vld_q <= '0;
			end else if (sb_we) begin
				sbox_vld_q[sb_waddr] <= 1'b1;
			end
		end
	end

	// key storage
	always_ff @(posedge clk) begin
		if (accept && s_tuser == OP_KEY && count_q < CNT_MAX) begin
			key_mem[count_q[KIDX_W-1:0]] <= s_tdata;
		end
		key_rd_q <= key_mem[kidx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			keyed_q  <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser == OP_KEY) begin
						keyed_q <= 1'b0;
						if (s_tlast) begin
							count_q <= '0;
							i_q     <= '0;
							j_q     <= '0;
						end else if (count_q < CNT_MAX) begin
							count_q <= count_q + CNT_W'(1);
						end
					end else if (accept && keyed_q) begin
						i_q <= i_q + 8'd1;
					end
				end
				ST_KS_RD_J: j_q <= j_ks;
				ST_KS_WR_J: begin
					i_q <= i_q + 8'd1;
					if (i_q == 8'hFF) begin
						keyed_q <= 1'b1;
						j_q     <= '0;
					end
				end
				ST_GEN_J: j_q <= j_gen;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				din_q <= s_tdata;
				if (s_tlast) begin
					len_q  <= (count_q < CNT_MAX) ? count_q + CNT_W'(1) : count_q;
					kidx_q <= '0;
				end
				res_q    <= '0;
				res_nk_q <= 1'b1;
			end
			ST_KS_RD_J: si_q <= sb_rd;
			ST_KS_WR_J: kidx_q <= (kidx_inc == len_q) ? '0 : kidx_inc[KIDX_W-1:0];
			ST_GEN_J:   si_q <= sb_rd;
			ST_GEN_T: begin
				sj_q <= sb_rd;
				if (t_idx == i_q) begin
					ks_src_q <= KS_FROM_I;
				end else if (t_idx == j_q) begin
					ks_src_q <= KS_FROM_J;
				end else begin
					ks_src_q <= KS_MEM;
				end
			end
			ST_GEN_WR: begin
				res_q    <= {ks, din_q ^ ks};
				res_nk_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= res_sel;
			m_tuser_q <= res_nk_sel;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: sv/rc4sc_chk.sv
// ---------------------------------------------------------------------------
// rc4sc_chk
// port-level checks for the rc4 stream cipher
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rc4sc_chk
	import rc4sc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,   // data_byte[7:0]
	input logic                   s_tuser,   // opcode
	input logic                   s_tlast,   // last_key
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,   // out_byte[7:0], keystream_byte[15:8]
	input logic                   m_tuser    // not_keyed
);

	logic s_acc;

	assign s_acc = s_tvalid && s_tready;

	// a stalled result word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

	// an unkeyed result carries no keystream
	`ASSERT_CLK(a_unkeyed_zero, clk, arst_n, !(m_tvalid && m_tuser) || m_tdata == '0, "unkeyed result with nonzero data")

	// the last key word starts scheduling, so the input side closes
	`ASSERT_NEXT(a_sched_busy, clk, arst_n, s_acc && s_tuser == OP_KEY && s_tlast, !s_tready, "word taken right after last key")

	// a data word keeps the input closed in the cycle after it is taken
	`ASSERT_NEXT(a_data_busy, clk, arst_n, s_acc && s_tuser == OP_DATA, !s_tready, "word taken right after data word")

endmodule

bind rc4_stream_cipher rc4sc_chk u_rc4sc_chk (.*);
